@@ rtl/core/crv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crv_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;
  localparam logic [4:0]  HdrCrcEnd = 5'd28;
  localparam logic [4:0]  HdrLast = 5'd31;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HDR_BAD = 2'd1,
    ST_PAY_BAD = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] record_id;
    logic [31:0] payload_length;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/crc32_record_verifier_unit.sv @@
// A result passes from the input register through the CRC update into the output register.
// Throughput: one byte per cycle while the output is not stalled; the byte-wise CRC update
// sits between the input register and the state registers, so each byte is handled as it leaves the input register.
// A result held at a stalled output stops the input register, which then stalls the input.
// Reset is asynchronous and active low; it clears the pipeline valids and returns
// the checker to idle with the CRC register at all ones.
`timescale 1ns / 1ps
`default_nettype none

module crc32_record_verifier_unit
  import crv_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         record_start_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] record_id_o,
  output logic [31:0] payload_length_o
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t res_out;

  assign in_item.data_byte = data_byte_i;
  assign in_item.record_start = record_start_i;
  assign fire = item_valid & advance;

  crv_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  crv_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  crv_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .res_valid_i(res_valid),
    .res_i      (res),
    .advance_o  (advance),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign status_o = res_out.status;
  assign record_id_o = res_out.record_id;
  assign payload_length_o = res_out.payload_length;

endmodule

`default_nettype wire

@@ rtl/core/crv_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crv_in_reg
  import crv_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire item_t item_i,
  input  wire        advance_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

@@ rtl/core/crv_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crv_engine
  import crv_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        fire_i,
  input  wire item_t item_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] hw_q [4];
  logic [31:0] hw_d [4];
  logic [31:0] rem_q, rem_d;

  phase_e      ph;
  logic [4:0]  pos;
  logic [31:0] crc;
  logic [31:0] rem;
  logic [1:0]  idx;

  always_comb begin
    ph  = item_i.record_start ? PH_HEADER : phase_q;
    pos = item_i.record_start ? 5'd0 : pos_q;
    crc = item_i.record_start ? CrcInit : crc_q;
    rem = item_i.record_start ? 32'd0 : rem_q;
    for (int i = 0; i < 4; i++) begin
      hw_d[i] = item_i.record_start ? 32'd0 : hw_q[i];
    end
    phase_d = ph;
    pos_d = pos;
    crc_d = crc;
    rem_d = rem;
    idx = pos[3:2];
    res_valid_o = 1'b0;
    res_o.status = ST_OK;
    if (!fire_i) begin
      phase_d = phase_q;
      pos_d = pos_q;
      crc_d = crc_q;
      rem_d = rem_q;
      for (int i = 0; i < 4; i++) begin
        hw_d[i] = hw_q[i];
      end
    end else begin
      case (ph)
        PH_HEADER: begin
          if (pos < HdrCrcEnd) begin
            crc_d = crc_byte(crc, item_i.data_byte);
          end
          if (pos[4]) begin
            hw_d[idx][{pos[1:0], 3'b000} +: 8] = item_i.data_byte;
          end
          pos_d = pos + 5'd1;
          if (pos == HdrLast) begin
            if (~crc_d != hw_d[3]) begin
              phase_d = PH_IDLE;
              res_valid_o = 1'b1;
              res_o.status = ST_HDR_BAD;
            end else begin
              rem_d = hw_d[1];
              crc_d = CrcInit;
              if (hw_d[1] == 32'd0) begin
                phase_d = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.status = (hw_d[2] == 32'd0) ? ST_OK : ST_PAY_BAD;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d = crc_byte(crc, item_i.data_byte);
          rem_d = rem - 32'd1;
          if (rem_d == 32'd0) begin
            phase_d = PH_IDLE;
            res_valid_o = 1'b1;
            res_o.status = (~crc_d == hw_d[2]) ? ST_OK : ST_PAY_BAD;
          end
        end
        default: begin
          phase_d = ph;
        end
      endcase
    end
    res_o.record_id = hw_d[0];
    res_o.payload_length = hw_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q <= 5'd0;
      crc_q <= CrcInit;
      rem_q <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        hw_q[i] <= 32'd0;
      end
    end else begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      crc_q <= crc_d;
      rem_q <= rem_d;
      for (int i = 0; i < 4; i++) begin
        hw_q[i] <= hw_d[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/crv_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crv_out_reg
  import crv_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          fire_i,
  input  wire          res_valid_i,
  input  wire result_t res_i,
  output logic         advance_o,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign advance_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = fire_i & res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

@@ rtl/core/crv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module crv_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  status_o,
  input wire [31:0] record_id_o,
  input wire [31:0] payload_length_o
);

  // The input side only backs up when a finished item is held at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output is free");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 2'd3))
    else $error("unused status code on the output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled item dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(status_o) && $stable(record_id_o) && $stable(payload_length_o)))
    else $error("stalled item changed");

endmodule

bind crc32_record_verifier_unit crv_checker u_crv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .record_id_o     (record_id_o),
  .payload_length_o(payload_length_o)
);

`default_nettype wire
